/* hw/rtl/aging_priority_scheduler_assert.svh */
// Assertion macros for the scheduler, clocked on clk, quiet while in reset.
`ifndef AGING_PRIORITY_SCHEDULER_ASSERT_SVH
`define AGING_PRIORITY_SCHEDULER_ASSERT_SVH

// Hold cond on every clock edge out of reset.
`define APS_CHECK(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("scheduler check failed");

// Require b whenever a holds.
`define APS_IMPLY(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("scheduler implication failed");

`endif

/* hw/rtl/aps_pkg.sv */
package aps_pkg;

	localparam int DEF_MAX_PROCS = 16;
	localparam int DEF_PRIO_BITS = 8;

	localparam logic [1:0] OP_ARRIVE = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_DONE   = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_SLOT_BUSY = 2'd1;
	localparam logic [1:0] STAT_DONE_IDLE = 2'd2;

	localparam logic REG_TIME_SLICE = 1'b0;
	localparam logic REG_AGING_THR  = 1'b1;

	localparam logic [15:0] RST_TIME_SLICE = 16'd4;
	localparam logic [15:0] RST_AGING_THR  = 16'd16;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] process_id;
		logic [7:0] process_priority;
	} in_t;

	typedef struct packed {
		logic [3:0] running_id;
		logic       running_valid;
		logic       dispatched;
		logic       from_vip;
		logic [1:0] status;
	} out_t;

	// Best candidate of one queue; sized for the largest slot count and priority.
	typedef struct packed {
		logic        valid;
		logic [7:0]  slot;
		logic [15:0] prio;
		logic [15:0] age;
	} cand_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

/* hw/rtl/aps_ram.sv */
module aps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/aps_pick.sv */
// Running minimum over one queue: lowest priority, then oldest stamp, then the first candidate offered.
module aps_pick (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          upd,
	input  aps_pkg::cand_t cand,
	output aps_pkg::cand_t best
);

	logic better;

	assign better = !best.valid || (cand.prio < best.prio) ||
		((cand.prio == best.prio) && (cand.age > best.age));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best.valid <= 1'b0;
			best.slot  <= '0;
			best.prio  <= '0;
			best.age   <= '0;
		end else if (clr) begin
			best.valid <= 1'b0;
		end else if (upd && better) begin
			best <= {1'b1, cand.slot, cand.prio, cand.age};
		end
	end

endmodule

/* hw/rtl/aging_priority_scheduler.sv */
// Channel  | Direction | Handshake          | Payload
// in       | input     | in_valid/in_ready  | in_data   (operation, id, priority)
// out      | output    | out_valid/out_ready| out_data  (running slot, flags, status)
// cfg      | input     | cfg_we             | cfg_index, cfg_data
//
// Arrive, done and undefined operations go from acceptance straight to the finish
// step, which registers the result.
// A tick runs two passes over the slot memory, one read per cycle through its single
// read port (age/promote, then minimum search), then the dispatch and finish steps.
// Reset clears slot flags, counters and the running process; slot memory needs no clear.
// A result waiting on out_ready does not block acceptance of the next transaction;
// only the finish step waits for the output register to free.
module aging_priority_scheduler #(
	parameter int MAX_PROCS = aps_pkg::DEF_MAX_PROCS,
	parameter int PRIO_BITS = aps_pkg::DEF_PRIO_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  aps_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output aps_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data
);

	localparam int IDW   = $clog2(MAX_PROCS);
	localparam int CW    = $clog2(MAX_PROCS + 1);
	localparam int ENT_W = PRIO_BITS + 32;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SW1  = 3'd1;
	localparam logic [2:0] S_SW2  = 3'd2;
	localparam logic [2:0] S_DISP = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]           state_q;
	logic [15:0]          ts_q, thr_q, oc_q, rc_q, pre_stamp_q;
	logic [MAX_PROCS-1:0] queued_q, vip_q;
	logic [IDW-1:0]       cur_q;
	logic                 cur_v_q, pre_q, disp_q, fv_q;
	logic [1:0]           stat_q;
	logic [CW-1:0]        ridx_q;
	logic                 rd_v_s1;
	logic [IDW-1:0]       rd_a_s1;

	logic                 accept;
	logic [IDW-1:0]       pid_idx;
	logic                 pid_busy;
	logic [PRIO_BITS-1:0] prio_in;
	logic [15:0]          rc_inc;

	logic                 ram_we;
	logic [IDW-1:0]       ram_waddr, ram_raddr;
	logic [ENT_W-1:0]     ram_wdata, ram_rdata;

	logic [PRIO_BITS-1:0] e_prio;
	logic [15:0]          e_wait, e_stamp, w_new, st_new;
	logic                 is_pre, prom, sw1_wr;

	aps_pkg::cand_t       cand, best_vip, best_ord;
	logic                 pick_clr, upd_vip, upd_ord;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign pid_idx  = IDW'(in_data.process_id);
	assign pid_busy = (32'(in_data.process_id) >= MAX_PROCS) || queued_q[pid_idx] ||
		(cur_v_q && (cur_q == pid_idx));
	assign prio_in  = PRIO_BITS'(in_data.process_priority);
	assign rc_inc   = aps_pkg::sat_inc(rc_q);

	// Slot entry: priority, waiting count, order stamp.
	assign e_prio  = ram_rdata[ENT_W-1:32];
	assign e_wait  = ram_rdata[31:16];
	assign e_stamp = ram_rdata[15:0];

	// Aging pass: the preempted slot restarts at zero wait with its preempt stamp, unless promoted.
	assign is_pre = pre_q && (rd_a_s1 == cur_q);
	assign w_new  = is_pre ? 16'd0 : aps_pkg::sat_inc(e_wait);
	assign prom   = !vip_q[rd_a_s1] && (w_new >= thr_q);
	assign st_new = prom ? oc_q : (is_pre ? pre_stamp_q : e_stamp);
	assign sw1_wr = (state_q == S_SW1) && rd_v_s1 && queued_q[rd_a_s1];

	always_comb begin
		if (sw1_wr) begin
			ram_we    = 1'b1;
			ram_waddr = rd_a_s1;
			ram_wdata = {e_prio, w_new, st_new};
		end else begin
			ram_we    = accept && (in_data.operation == aps_pkg::OP_ARRIVE) && !pid_busy;
			ram_waddr = pid_idx;
			ram_wdata = {prio_in, 16'd0, oc_q};
		end
	end

	assign ram_raddr = (ridx_q < CW'(MAX_PROCS)) ? ridx_q[IDW-1:0] : '0;

	aps_ram #(.WIDTH(ENT_W), .DEPTH(MAX_PROCS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Search pass: age is measured against the final order counter.
	assign cand.valid = 1'b1;
	assign cand.slot  = 8'(rd_a_s1);
	assign cand.prio  = 16'(e_prio);
	assign cand.age   = oc_q - e_stamp;
	assign pick_clr   = accept;
	assign upd_vip    = (state_q == S_SW2) && rd_v_s1 && queued_q[rd_a_s1] && vip_q[rd_a_s1];
	assign upd_ord    = (state_q == S_SW2) && rd_v_s1 && queued_q[rd_a_s1] && !vip_q[rd_a_s1];

	aps_pick u_pick_vip (
		.clk (clk), .arst_n (arst_n), .clr (pick_clr), .upd (upd_vip),
		.cand (cand), .best (best_vip)
	);

	aps_pick u_pick_ord (
		.clk (clk), .arst_n (arst_n), .clr (pick_clr), .upd (upd_ord),
		.cand (cand), .best (best_ord)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ts_q        <= aps_pkg::RST_TIME_SLICE;
			thr_q       <= aps_pkg::RST_AGING_THR;
			oc_q        <= '0;
			rc_q        <= '0;
			pre_stamp_q <= '0;
			queued_q    <= '0;
			vip_q       <= '0;
			cur_q       <= '0;
			cur_v_q     <= 1'b0;
			pre_q       <= 1'b0;
			disp_q      <= 1'b0;
			fv_q        <= 1'b0;
			stat_q      <= aps_pkg::STAT_OK;
			ridx_q      <= '0;
			rd_v_s1     <= 1'b0;
			rd_a_s1     <= '0;
			out_valid   <= 1'b0;
			out_data    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					aps_pkg::REG_TIME_SLICE: ts_q  <= cfg_data;
					aps_pkg::REG_AGING_THR:  thr_q <= cfg_data;
					default: ;
				endcase
			end

			// Drop a delivered result; the finish step reloads it itself.
			if (out_valid && out_ready && (state_q != S_FIN)) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						disp_q <= 1'b0;
						fv_q   <= 1'b0;
						unique case (in_data.operation)
							aps_pkg::OP_ARRIVE: begin
								pre_q   <= 1'b0;
								state_q <= S_FIN;
								if (pid_busy) begin
									stat_q <= aps_pkg::STAT_SLOT_BUSY;
								end else begin
									stat_q            <= aps_pkg::STAT_OK;
									queued_q[pid_idx] <= 1'b1;
									vip_q[pid_idx]    <= 1'b0;
									oc_q              <= oc_q + 16'd1;
								end
							end
							aps_pkg::OP_DONE: begin
								pre_q   <= 1'b0;
								state_q <= S_FIN;
								if (cur_v_q) begin
									stat_q  <= aps_pkg::STAT_OK;
									cur_v_q <= 1'b0;
									rc_q    <= '0;
								end else begin
									stat_q <= aps_pkg::STAT_DONE_IDLE;
								end
							end
							aps_pkg::OP_TICK: begin
								stat_q  <= aps_pkg::STAT_OK;
								ridx_q  <= '0;
								rd_v_s1 <= 1'b0;
								state_q <= S_SW1;
								// Preempt: back to the ordinary tail with a fresh stamp.
								if (cur_v_q && (rc_inc >= ts_q)) begin
									pre_q           <= 1'b1;
									pre_stamp_q     <= oc_q;
									oc_q            <= oc_q + 16'd1;
									queued_q[cur_q] <= 1'b1;
									vip_q[cur_q]    <= 1'b0;
									cur_v_q         <= 1'b0;
									rc_q            <= '0;
								end else begin
									pre_q <= 1'b0;
									if (cur_v_q) begin
										rc_q <= rc_inc;
									end
								end
							end
							default: begin
								pre_q   <= 1'b0;
								stat_q  <= aps_pkg::STAT_OK;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SW1, S_SW2: begin
					if (ridx_q < CW'(MAX_PROCS)) begin
						rd_v_s1 <= 1'b1;
						rd_a_s1 <= ridx_q[IDW-1:0];
						ridx_q  <= ridx_q + CW'(1);
					end else begin
						rd_v_s1 <= 1'b0;
						if (!rd_v_s1) begin
							ridx_q  <= '0;
							state_q <= (state_q == S_SW1) ? S_SW2 : S_DISP;
						end
					end
					// Promote in slot order, each taking the next stamp.
					if (sw1_wr && prom) begin
						vip_q[rd_a_s1] <= 1'b1;
						oc_q           <= oc_q + 16'd1;
					end
				end
				S_DISP: begin
					if (!cur_v_q && (best_vip.valid || best_ord.valid)) begin
						priority if (best_vip.valid) begin
							cur_q <= IDW'(best_vip.slot);
							queued_q[IDW'(best_vip.slot)] <= 1'b0;
							vip_q[IDW'(best_vip.slot)]    <= 1'b0;
							fv_q <= 1'b1;
						end else begin
							cur_q <= IDW'(best_ord.slot);
							queued_q[IDW'(best_ord.slot)] <= 1'b0;
							vip_q[IDW'(best_ord.slot)]    <= 1'b0;
						end
						cur_v_q <= 1'b1;
						rc_q    <= '0;
						disp_q  <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					// Hold until the output register is free.
					if (!out_valid || out_ready) begin
						out_valid              <= 1'b1;
						out_data.running_id    <= cur_v_q ? 4'(cur_q) : 4'd0;
						out_data.running_valid <= cur_v_q;
						out_data.dispatched    <= disp_q;
						out_data.from_vip      <= fv_q;
						out_data.status        <= stat_q;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`include "aging_priority_scheduler_assert.svh"

	`APS_IMPLY(a_disp_runs, out_valid && out_data.dispatched, out_data.running_valid)
	`APS_IMPLY(a_run_not_queued, cur_v_q, !queued_q[cur_q])
	`APS_CHECK(a_vip_only_queued, (vip_q & ~queued_q) == '0)
	`APS_IMPLY(a_vip_flag_disp, out_valid && out_data.from_vip, out_data.dispatched)

endmodule

/* tb/aging_priority_scheduler_tb.sv */
`timescale 1ns / 100ps

// Scheduler testbench: a queue-fed driver pushes arrive, tick, done and undefined ops,
// a clocked monitor compares every result with the scoreboard filled by the predictor.
module aging_priority_scheduler_tb;

	localparam int NPROC = 16;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	aps_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	aps_pkg::out_t out_data;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;

	aging_priority_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Scheduler image kept by the predictor.
	logic [15:0] slice_len;
	logic [15:0] age_limit;
	logic q_on [NPROC];
	logic q_vip [NPROC];
	logic [7:0] q_prio [NPROC];
	logic [15:0] q_wait [NPROC];
	logic [15:0] q_stamp [NPROC];
	logic [15:0] stamp_ctr;
	logic [3:0] run_slot;
	logic run_on;
	logic [15:0] run_ticks;

	aps_pkg::in_t pending_ops[$];
	aps_pkg::out_t expected_sched[$];
	int mismatches = 0;
	bit tail_calm;
	bit hold_off;
	logic in_acc_q;

	function automatic logic [15:0] bump16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic void put_tail(input int s, input logic vip);
		q_on[s] = 1'b1;
		q_vip[s] = vip;
		q_stamp[s] = stamp_ctr;
		stamp_ctr = stamp_ctr + 16'd1;
	endfunction

	function automatic int best_in(input logic vip);
		int best;
		logic [15:0] best_age;
		logic [15:0] a;
		best = NPROC;
		best_age = '0;
		for (int i = 0; i < NPROC; i++) begin
			if (q_on[i] && q_vip[i] == vip) begin
				a = stamp_ctr - q_stamp[i];
				if (best == NPROC || q_prio[i] < q_prio[best] ||
				    (q_prio[i] == q_prio[best] && a > best_age)) begin
					best = i;
					best_age = a;
				end
			end
		end
		return best;
	endfunction

	// Advance the scheduler image by one transaction and return its result.
	function automatic aps_pkg::out_t schedule_step(input aps_pkg::in_t t);
		aps_pkg::out_t r;
		int s;
		logic vip;
		r = '0;
		r.status = aps_pkg::STAT_OK;
		if (t.operation == aps_pkg::OP_ARRIVE) begin
			if (q_on[t.process_id] || (run_on && run_slot == t.process_id)) begin
				r.status = aps_pkg::STAT_SLOT_BUSY;
			end else begin
				q_prio[t.process_id] = t.process_priority;
				q_wait[t.process_id] = '0;
				put_tail(int'(t.process_id), 1'b0);
			end
		end else if (t.operation == aps_pkg::OP_DONE) begin
			if (run_on) begin
				run_on = 1'b0;
				run_ticks = '0;
			end else begin
				r.status = aps_pkg::STAT_DONE_IDLE;
			end
		end else if (t.operation == aps_pkg::OP_TICK) begin
			for (int i = 0; i < NPROC; i++)
				if (q_on[i]) q_wait[i] = bump16(q_wait[i]);
			if (run_on) begin
				run_ticks = bump16(run_ticks);
				if (run_ticks >= slice_len) begin
					q_wait[run_slot] = '0;
					put_tail(int'(run_slot), 1'b0);
					run_on = 1'b0;
					run_ticks = '0;
				end
			end
			for (int i = 0; i < NPROC; i++)
				if (q_on[i] && !q_vip[i] && q_wait[i] >= age_limit) put_tail(i, 1'b1);
			if (!run_on) begin
				vip = 1'b1;
				s = best_in(1'b1);
				if (s >= NPROC) begin
					s = best_in(1'b0);
					vip = 1'b0;
				end
				if (s < NPROC) begin
					q_on[s] = 1'b0;
					q_vip[s] = 1'b0;
					q_wait[s] = '0;
					run_slot = s[3:0];
					run_on = 1'b1;
					run_ticks = '0;
					r.dispatched = 1'b1;
					r.from_vip = vip;
				end
			end
		end
		r.running_id = run_on ? run_slot : 4'd0;
		r.running_valid = run_on;
		return r;
	endfunction

	// Driver: present the head of the pending queue, with random idle bursts.
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_acc_q) begin
				// hold the transaction until taken
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (!tail_calm && $urandom_range(0, 9) == 0) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(0, 12);
			end else if (pending_ops.size() > 0) begin
				in_valid <= 1'b1;
				in_data <= pending_ops.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stalls: random bursts, or a long hold-off on request.
	int stall_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (hold_off) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!tail_calm && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 12);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: compare each result with the oldest expectation, then predict
	// the transaction accepted at this edge.
	always @(posedge clk) begin
		aps_pkg::out_t e;
		in_acc_q <= arst_n && in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			if (expected_sched.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_data);
			end else begin
				e = expected_sched.pop_front();
				if (out_data !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p got %p", e, out_data);
				end
			end
		end
		if (arst_n && in_valid && in_ready)
			expected_sched = {expected_sched, schedule_step(in_data)};
	end

	function automatic aps_pkg::in_t make_op(input logic [1:0] op, input logic [3:0] id,
	                                         input logic [7:0] pr);
		aps_pkg::in_t t;
		t.operation = op;
		t.process_id = id;
		t.process_priority = pr;
		return t;
	endfunction

	task automatic add_op(input logic [1:0] op, input logic [3:0] id, input logic [7:0] pr);
		pending_ops = {pending_ops, make_op(op, id, pr)};
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == aps_pkg::REG_TIME_SLICE) slice_len = val;
		else age_limit = val;
	endtask

	// Let the queues drain and the block settle before touching registers.
	task automatic drain_all();
		while (pending_ops.size() > 0 || in_valid || expected_sched.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Random load: arrivals, done and rare undefined ops mixed into a tick-heavy stream.
	task automatic queue_random(input int n);
		int k;
		logic [1:0] op;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 30) op = aps_pkg::OP_ARRIVE;
			else if (k < 80) op = aps_pkg::OP_TICK;
			else if (k < 97) op = aps_pkg::OP_DONE;
			else op = 2'd3;
			add_op(op, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = aps_pkg::REG_TIME_SLICE;
		cfg_data = '0;
		tail_calm = 1'b0;
		hold_off = 1'b0;
		slice_len = aps_pkg::RST_TIME_SLICE;
		age_limit = aps_pkg::RST_AGING_THR;
		for (int i = 0; i < NPROC; i++) begin
			q_on[i] = 1'b0;
			q_vip[i] = 1'b0;
			q_prio[i] = '0;
			q_wait[i] = '0;
			q_stamp[i] = '0;
		end
		stamp_ctr = '0;
		run_slot = '0;
		run_on = 1'b0;
		run_ticks = '0;
		repeat (10) @(posedge clk);
		arst_n = 1'b1;

		// Directed: done while idle, tick on empty table, extreme priorities,
		// busy slot, running slot rearrive, undefined op, equal priorities.
		add_op(aps_pkg::OP_DONE, 4'd0, 8'd0);
		add_op(aps_pkg::OP_TICK, 4'd0, 8'd0);
		add_op(aps_pkg::OP_ARRIVE, 4'd0, 8'd255);
		add_op(aps_pkg::OP_ARRIVE, 4'd15, 8'd0);
		add_op(aps_pkg::OP_ARRIVE, 4'd15, 8'd7);
		add_op(aps_pkg::OP_ARRIVE, 4'd5, 8'd255);
		add_op(aps_pkg::OP_ARRIVE, 4'd10, 8'hAA);
		add_op(aps_pkg::OP_ARRIVE, 4'd6, 8'h55);
		add_op(2'd3, 4'd9, 8'd1);
		add_op(aps_pkg::OP_TICK, 4'd0, 8'd0);
		add_op(aps_pkg::OP_ARRIVE, 4'd15, 8'd3);
		for (int i = 0; i < 10; i++) add_op(aps_pkg::OP_TICK, 4'd0, 8'd0);
		add_op(aps_pkg::OP_DONE, 4'd0, 8'd0);
		add_op(aps_pkg::OP_TICK, 4'd0, 8'd0);
		drain_all();

		// Tight settings: preempt every tick, promote at once.
		write_reg(aps_pkg::REG_TIME_SLICE, 16'd1);
		write_reg(aps_pkg::REG_AGING_THR, 16'd1);
		queue_random(300);
		drain_all();

		// Extremes: never preempt or promote within the run.
		write_reg(aps_pkg::REG_TIME_SLICE, 16'hFFFF);
		write_reg(aps_pkg::REG_AGING_THR, 16'hFFFF);
		queue_random(200);
		// Hold the receiver off long enough for the block to stall its input.
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
		drain_all();

		// Zero registers and mid-range settings.
		write_reg(aps_pkg::REG_TIME_SLICE, 16'd0);
		write_reg(aps_pkg::REG_AGING_THR, 16'd0);
		queue_random(250);
		drain_all();
		write_reg(aps_pkg::REG_TIME_SLICE, 16'd3);
		write_reg(aps_pkg::REG_AGING_THR, 16'd8);
		queue_random(650);
		drain_all();
		write_reg(aps_pkg::REG_TIME_SLICE, 16'd4);
		write_reg(aps_pkg::REG_AGING_THR, 16'd16);
		queue_random(250);
		while (pending_ops.size() > 100) @(posedge clk);
		tail_calm = 1'b1;
		drain_all();

		if (mismatches == 0 && expected_sched.size() == 0)
			$display("aging_priority_scheduler test passed");
		else
			$display("aging_priority_scheduler test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("aging_priority_scheduler test failed");
		$finish;
	end

endmodule

/* aging_priority_scheduler.f */
+incdir+hw/rtl
hw/rtl/aps_pkg.sv
hw/rtl/aps_ram.sv
hw/rtl/aps_pick.sv
hw/rtl/aging_priority_scheduler.sv
tb/aging_priority_scheduler_tb.sv
